>>> design/orq_pkg.sv
// Shared types, codes and constants for the ordered ready queue.
`default_nettype none
package orq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CFG_W         = 5;

  // commands
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NOKEY = 2'd3;

  // configuration register indexes
  localparam logic CFG_QUEUE_LIMIT = 1'b0;
  localparam logic CFG_ORDER_MODE  = 1'b1;

  // ordering modes
  localparam logic [1:0] MODE_FIFO = 2'd0;
  localparam logic [1:0] MODE_TIME = 2'd1;
  localparam logic [1:0] MODE_PRIO = 2'd2;

  localparam logic [4:0] LIMIT_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] entry_key;
    logic [15:0] burst_time;
    logic [7:0]  entry_priority;
    logic [15:0] arrival_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_key;
    logic [15:0] out_time;
    logic [7:0]  out_priority;
    logic [15:0] out_arrival;
    logic [4:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] arrival;
  } slot_t;

  typedef enum logic [2:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_IDX_M2,
    RD_IDX_P1,
    RD_IDX_P2
  } rd_sel_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       wr_en;
    logic       wr_item;
    idx_op_t    idx_op;
    logic       found_cap;
    logic       out_load;
    logic [1:0] status;
    cnt_op_t    cnt_op;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] command;
    logic       empty;
    logic       full;
    logic       ordered;
    logic       gt;
    logic       key_match;
    logic       idx_is_one;
    logic       more_srch;
    logic       more_shift;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> design/orq_datapath.sv
// Datapath: slot memory, walk index, count, config registers and result register.
`default_nettype none
module orq_datapath #(
  parameter int DEPTH = orq_pkg::DEPTH_DEFAULT
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  orq_pkg::in_item_t   in_data,
  input  orq_pkg::dp_cmd_t    cmd,
  output orq_pkg::dp_stat_t   stat,
  input  wire                 cfg_wr_en,
  input  wire                 cfg_index,
  input  wire [orq_pkg::CFG_W-1:0] cfg_wdata,
  output logic                out_valid,
  input  wire                 out_stall,
  output orq_pkg::out_item_t  out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  orq_pkg::slot_t mem [DEPTH];

  orq_pkg::slot_t    rdata_r;
  orq_pkg::slot_t    found_r;
  orq_pkg::in_item_t item_r;
  orq_pkg::slot_t    wdata;
  logic [CW-1:0]     idx_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_nxt;
  logic [CW-1:0]     eff_lim;
  logic [CW-1:0]     rd_idx;
  logic [AW-1:0]     raddr;
  logic [4:0]        limit_r;
  logic [1:0]        mode_r;
  logic              out_valid_r;
  orq_pkg::out_item_t out_r;
  logic              out_free;

  // effective limit: zero or above depth means the full depth
  always_comb begin
    if (limit_r == 5'd0 || int'(limit_r) > DEPTH) begin
      eff_lim = CW'(DEPTH);
    end else begin
      eff_lim = CW'(limit_r);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      orq_pkg::RD_IDX_M1: rd_idx = idx_r - CW'(1);
      orq_pkg::RD_IDX_M2: rd_idx = idx_r - CW'(2);
      orq_pkg::RD_IDX_P1: rd_idx = idx_r + CW'(1);
      orq_pkg::RD_IDX_P2: rd_idx = idx_r + CW'(2);
      default:            rd_idx = idx_r;
    endcase
  end
  assign raddr = rd_idx[AW-1:0];

  assign wdata = cmd.wr_item ?
    '{key: item_r.entry_key, burst: item_r.burst_time,
      prio: item_r.entry_priority, arrival: item_r.arrival_time} : rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[idx_r[AW-1:0]] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    case (cmd.cnt_op)
      orq_pkg::CNT_INC: cnt_nxt = cnt_r + CW'(1);
      orq_pkg::CNT_DEC: cnt_nxt = cnt_r - CW'(1);
      default:          cnt_nxt = cnt_r;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      limit_r     <= orq_pkg::LIMIT_RESET;
      mode_r      <= orq_pkg::MODE_FIFO;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          orq_pkg::CFG_QUEUE_LIMIT: limit_r <= cfg_wdata;
          orq_pkg::CFG_ORDER_MODE:  mode_r  <= cfg_wdata[1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r  <= in_data;
      found_r <= '0;
      idx_r   <= (in_data.command == orq_pkg::CMD_INSERT) ? cnt_r : '0;
    end else begin
      if (cmd.found_cap) begin
        found_r <= rdata_r;
      end
      case (cmd.idx_op)
        orq_pkg::IDX_INC: idx_r <= idx_r + CW'(1);
        orq_pkg::IDX_DEC: idx_r <= idx_r - CW'(1);
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_r.status       <= cmd.status;
      out_r.out_key      <= found_r.key;
      out_r.out_time     <= found_r.burst;
      out_r.out_priority <= found_r.prio;
      out_r.out_arrival  <= found_r.arrival;
      out_r.entry_count  <= 5'(cnt_nxt);
    end
  end

  always_comb begin
    stat.command    = item_r.command;
    stat.empty      = (cnt_r == '0);
    stat.full       = (cnt_r >= eff_lim);
    stat.ordered    = (mode_r == orq_pkg::MODE_TIME) || (mode_r == orq_pkg::MODE_PRIO);
    case (mode_r)
      orq_pkg::MODE_TIME: stat.gt = (rdata_r.burst > item_r.burst_time);
      orq_pkg::MODE_PRIO: stat.gt = (rdata_r.prio > item_r.entry_priority);
      default:            stat.gt = 1'b0;
    endcase
    stat.key_match  = (rdata_r.key == item_r.entry_key);
    stat.idx_is_one = (idx_r == CW'(1));
    stat.more_srch  = ((CW+1)'(idx_r) + (CW+1)'(1)) < (CW+1)'(cnt_r);
    stat.more_shift = ((CW+1)'(idx_r) + (CW+1)'(2)) < (CW+1)'(cnt_r);
    stat.out_free   = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> idx_r <= cnt_r)
    else $error("slot write beyond the held entries");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result register overwritten while pending");

  a_cnt_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.out_load |=> $stable(cnt_r))
    else $error("entry count changed without a result");

endmodule
`default_nettype wire

>>> design/orq_ctrl.sv
// Controller: sequences insert walks, key searches and gap closing.
`default_nettype none
module orq_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  orq_pkg::dp_stat_t stat,
  output orq_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_INS,
    S_INS_WR,
    S_SRCH,
    S_SHIFT,
    S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  orq_pkg::cnt_op_t  res_cnt_r, res_cnt_nxt;

  assign in_stall = !rst_n || (state_r != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = orq_pkg::RD_IDX;
    cmd.idx_op     = orq_pkg::IDX_HOLD;
    cmd.cnt_op     = orq_pkg::CNT_HOLD;
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_cnt_nxt    = res_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_status_nxt = orq_pkg::ST_DONE;
        res_cnt_nxt    = orq_pkg::CNT_HOLD;
        unique case (stat.command) inside
          orq_pkg::CMD_INSERT: begin
            if (stat.full) begin
              res_status_nxt = orq_pkg::ST_FULL;
              state_nxt      = S_FIN;
            end else if (stat.ordered && !stat.empty) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = orq_pkg::RD_IDX_M1;
              state_nxt  = S_INS;
            end else begin
              state_nxt = S_INS_WR;
            end
          end
          orq_pkg::CMD_POP, orq_pkg::CMD_REMOVE: begin
            if (stat.empty) begin
              res_status_nxt = orq_pkg::ST_EMPTY;
              state_nxt      = S_FIN;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = orq_pkg::RD_IDX;
              state_nxt  = S_SRCH;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_INS: begin
        // slot idx-1 is in the read register
        cmd.wr_en = 1'b1;
        if (stat.gt) begin
          cmd.idx_op = orq_pkg::IDX_DEC;
          if (stat.idx_is_one) begin
            state_nxt = S_INS_WR;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = orq_pkg::RD_IDX_M2;
          end
        end else begin
          cmd.wr_item = 1'b1;
          res_cnt_nxt = orq_pkg::CNT_INC;
          state_nxt   = S_FIN;
        end
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_item = 1'b1;
        res_cnt_nxt = orq_pkg::CNT_INC;
        state_nxt   = S_FIN;
      end
      S_SRCH: begin
        // slot idx is in the read register; prefetch idx+1
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = orq_pkg::RD_IDX_P1;
        if (stat.command == orq_pkg::CMD_POP || stat.key_match) begin
          cmd.found_cap = 1'b1;
          if (stat.more_srch) begin
            state_nxt = S_SHIFT;
          end else begin
            res_cnt_nxt = orq_pkg::CNT_DEC;
            state_nxt   = S_FIN;
          end
        end else if (stat.more_srch) begin
          cmd.idx_op = orq_pkg::IDX_INC;
        end else begin
          res_status_nxt = orq_pkg::ST_NOKEY;
          state_nxt      = S_FIN;
        end
      end
      S_SHIFT: begin
        // move slot idx+1 down into slot idx
        cmd.wr_en  = 1'b1;
        cmd.idx_op = orq_pkg::IDX_INC;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = orq_pkg::RD_IDX_P2;
        if (!stat.more_shift) begin
          res_cnt_nxt = orq_pkg::CNT_DEC;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.status   = res_status_r;
          cmd.cnt_op   = res_cnt_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    res_status_r <= res_status_nxt;
    res_cnt_r    <= res_cnt_nxt;
  end

endmodule
`default_nettype wire

>>> design/ordered_ready_queue_core.sv
// Top level of the ordered ready queue: controller plus datapath.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  in_     | input     | in_valid / in_stall     | in_data  (orq_pkg::in_item_t)
//  out_    | output    | out_valid / out_stall   | out_data (orq_pkg::out_item_t)
//  cfg_    | input     | cfg_wr_en, no wait      | cfg_index, cfg_wdata
//
//  One command is in flight at a time. Full, empty and unknown commands go to the
//  result directly; a tail insert writes its slot; an ordered insert moves each
//  larger entry up from the tail; pop takes the head, remove searches by key,
//  and later entries shift down; input is taken in the cycle after a result loads.
//  Synchronous active-low reset empties the queue, sets limit 16 and FIFO mode.
//  A result held by out_stall blocks only the following result, not the next input.
`default_nettype none
module ordered_ready_queue_core #(
  parameter int DEPTH = orq_pkg::DEPTH_DEFAULT
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  orq_pkg::in_item_t        in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output orq_pkg::out_item_t       out_data,
  input  wire                      cfg_wr_en,
  input  wire                      cfg_index,
  input  wire [orq_pkg::CFG_W-1:0] cfg_wdata
);

  orq_pkg::dp_cmd_t  cmd;
  orq_pkg::dp_stat_t stat;

  orq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  orq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
